[design/rpy_pkg.sv]
// rpy_pkg: widths, coefficients and the stage record shared by the rgb565 to
// packed yuv420 converter. No dependencies.

package rpy_pkg;

  localparam int MaxLinePairs = 1024;
  localparam int ColW         = $clog2(MaxLinePairs);
  localparam int CfgW         = 11;
  localparam int PixW         = 16;
  localparam int ByteW        = 8;

  localparam logic [CfgW-1:0] PairsPerLineReset = CfgW'(320);

  // bt.601 style fixed point weights, scaled by 256
  localparam int signed LumaR = 77;
  localparam int signed LumaG = 150;
  localparam int signed LumaB = 29;
  localparam int signed UR    = -43;
  localparam int signed UG    = -85;
  localparam int signed UB    = 128;
  localparam int signed VR    = 128;
  localparam int signed VG    = -107;
  localparam int signed VB    = -21;
  localparam int signed ChromaBias = 128;

  localparam logic [4:0] Mask5 = 5'h1F;
  localparam logic [5:0] Mask6 = 6'h3F;

  // one pair after line tracking, waiting for the color math
  typedef struct packed {
    logic [PixW-1:0] first_pixel;
    logic [PixW-1:0] second_pixel;
    logic            odd_line;
    logic            line_end;
  } rpy_stage_t;

endpackage

[design/rpy_if.sv]
// rpy_if: valid/ready channel interfaces of the converter: pixel pair input,
// packed triple output and the line length configuration. Uses rpy_pkg.

interface rpy_pair_if import rpy_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] first_pixel;
  logic [PixW-1:0] second_pixel;
  logic            frame_start;

  modport source (output valid, first_pixel, second_pixel, frame_start, input ready);
  modport sink   (input valid, first_pixel, second_pixel, frame_start, output ready);
endinterface

interface rpy_triple_if import rpy_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] chroma_byte;
  logic [ByteW-1:0] luma_left;
  logic [ByteW-1:0] luma_right;
  logic             chroma_is_v;
  logic             line_end;

  modport source (output valid, chroma_byte, luma_left, luma_right, chroma_is_v, line_end,
                  input ready);
  modport sink   (input valid, chroma_byte, luma_left, luma_right, chroma_is_v, line_end,
                  output ready);
endinterface

interface rpy_cfg_if import rpy_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[design/rpy_line_ctrl.sv]
// rpy_line_ctrl: line length register, pair column and line parity tracking,
// and the input register stage. Uses rpy_pkg and the rpy_if interfaces.

module rpy_line_ctrl import rpy_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpy_pair_if.sink   pix_i,
  rpy_cfg_if.sink    cfg_i,
  output logic       stage_valid_o,
  input  logic       stage_ready_i,
  output rpy_stage_t stage_o
);

  logic [CfgW-1:0] pairs_q;
  logic [ColW-1:0] col_q, col_d;
  logic            odd_q, odd_d;
  logic            stage_valid_q;
  rpy_stage_t      stage_q;

  logic [ColW-1:0] last_col;
  logic [ColW-1:0] col_eff;
  logic            odd_eff;
  logic            last;
  logic            acc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_q <= PairsPerLineReset;
    end else if (cfg_i.valid) begin
      pairs_q <= cfg_i.data;
    end
  end

  // zero acts as one pair, oversize saturates
  always_comb begin
    if (pairs_q == '0) begin
      last_col = '0;
    end else if (int'(pairs_q) > MaxLinePairs) begin
      last_col = ColW'(MaxLinePairs - 1);
    end else begin
      last_col = ColW'(pairs_q - CfgW'(1));
    end
  end

  assign col_eff = pix_i.frame_start ? '0 : col_q;
  assign odd_eff = pix_i.frame_start ? 1'b0 : odd_q;
  assign last    = (col_eff >= last_col);

  assign pix_i.ready = !stage_valid_q || stage_ready_i;
  assign acc         = pix_i.valid && pix_i.ready;

  always_comb begin
    col_d = col_q;
    odd_d = odd_q;
    if (acc) begin
      if (last) begin
        col_d = '0;
        odd_d = !odd_eff;
      end else begin
        col_d = col_eff + ColW'(1);
        odd_d = odd_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      odd_q         <= 1'b0;
      stage_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      odd_q <= odd_d;
      if (pix_i.ready) begin
        stage_valid_q <= pix_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      stage_q.first_pixel  <= pix_i.first_pixel;
      stage_q.second_pixel <= pix_i.second_pixel;
      stage_q.odd_line     <= odd_eff;
      stage_q.line_end     <= last;
    end
  end

  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;

`ifndef NO_ASSERTIONS
  a_frame_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && pix_i.frame_start |=> stage_valid_q && !stage_q.odd_line)
    else $error("frame start pair not on an even line");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (stage_q.line_end == (col_q == '0)) &&
            (stage_q.line_end == (odd_q != stage_q.odd_line)))
    else $error("column wrap and parity toggle disagree with line end");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(col_q) && $stable(odd_q))
    else $error("line state moved without an accepted pair");
`endif

endmodule

[design/rpy_convert.sv]
// rpy_convert: rgb565 expansion, luma of both pixels and u or v chroma of the
// left pixel, into the result register. Uses rpy_pkg and rpy_triple_if.

module rpy_convert import rpy_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        stage_valid_i,
  output logic        stage_ready_o,
  input  rpy_stage_t  stage_i,
  rpy_triple_if.source yuv_o
);

  function automatic logic [ByteW-1:0] luma_of(input logic [PixW-1:0] px);
    logic [ByteW-1:0] r, g, b;
    logic [15:0]      sum;
    r   = {px[15:11] & Mask5, 3'b000};
    g   = {px[10:5] & Mask6, 2'b00};
    b   = {px[4:0] & Mask5, 3'b000};
    // peak is 64088, so the top byte never overflows
    sum = 16'(LumaR * int'(r) + LumaG * int'(g) + LumaB * int'(b));
    return sum[15:8];
  endfunction

  logic [ByteW-1:0]  r0, g0, b0;
  logic signed [16:0] sum_c;
  logic signed [9:0]  chroma_s;
  logic [ByteW-1:0]  chroma;
  logic              acc;
  logic              out_valid_q;

  logic [ByteW-1:0] chroma_q, luma_l_q, luma_r_q;
  logic             is_v_q, line_end_q;

  assign r0 = {stage_i.first_pixel[15:11], 3'b000};
  assign g0 = {stage_i.first_pixel[10:5], 2'b00};
  assign b0 = {stage_i.first_pixel[4:0], 3'b000};

  always_comb begin
    if (stage_i.odd_line) begin
      sum_c = 17'(VR * int'(r0) + VG * int'(g0) + VB * int'(b0));
    end else begin
      sum_c = 17'(UR * int'(r0) + UG * int'(g0) + UB * int'(b0));
    end
    // arithmetic shift gives the floor
    chroma_s = 10'(sum_c >>> 8) + 10'(ChromaBias);
    if (chroma_s < 0) begin
      chroma = '0;
    end else if (chroma_s > 10'sd255) begin
      chroma = '1;
    end else begin
      chroma = chroma_s[7:0];
    end
  end

  assign stage_ready_o = !out_valid_q || yuv_o.ready;
  assign acc           = stage_valid_i && stage_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_ready_o) begin
      out_valid_q <= stage_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      chroma_q   <= chroma;
      luma_l_q   <= luma_of(stage_i.first_pixel);
      luma_r_q   <= luma_of(stage_i.second_pixel);
      is_v_q     <= stage_i.odd_line;
      line_end_q <= stage_i.line_end;
    end
  end

  assign yuv_o.valid       = out_valid_q;
  assign yuv_o.chroma_byte = chroma_q;
  assign yuv_o.luma_left   = luma_l_q;
  assign yuv_o.luma_right  = luma_r_q;
  assign yuv_o.chroma_is_v = is_v_q;
  assign yuv_o.line_end    = line_end_q;

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_q)
    else $error("accepted pair produced no result");

  a_tags_carried: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (is_v_q == $past(stage_i.odd_line)) && (line_end_q == $past(stage_i.line_end)))
    else $error("line tags lost between stage and result");

  a_chroma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (chroma_q >= 8'd2) && (chroma_q <= 8'd252))
    else $error("chroma outside the reachable range, sign handling slipped");
`endif

endmodule

[design/rgb565_to_packed_yuv420.sv]
// rgb565_to_packed_yuv420: top level, line tracking stage then color math
// stage. Uses rpy_pkg, rpy_if, rpy_line_ctrl and rpy_convert.
//
//   port    dir  carries                                         request
//   pix_i   in   first_pixel, second_pixel, frame_start          one pixel pair
//   yuv_o   out  chroma_byte, luma_left, luma_right,             one packed triple
//                chroma_is_v, line_end
//   cfg_i   in   data: pairs_per_line                            one register write
//
// one pair per clock sustained while yuv_o is not stalled; a result reaches yuv_o
// through the input register, then the result register
// reset clears the line position to column zero of an even line and the line
// length to 320 pairs
// a stall on yuv_o backs up through both stages; each stage refills as soon
// as its downstream side frees up

module rgb565_to_packed_yuv420 import rpy_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  rpy_pair_if.sink      pix_i,
  rpy_cfg_if.sink       cfg_i,
  rpy_triple_if.source  yuv_o
);

  logic       stage_valid;
  logic       stage_ready;
  rpy_stage_t stage;

  rpy_line_ctrl u_line_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_i         (pix_i),
    .cfg_i         (cfg_i),
    .stage_valid_o (stage_valid),
    .stage_ready_i (stage_ready),
    .stage_o       (stage)
  );

  rpy_convert u_convert (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid),
    .stage_ready_o (stage_ready),
    .stage_i       (stage),
    .yuv_o         (yuv_o)
  );

endmodule

[sim/rpy_yuv_checker.sv]
`timescale 1ns / 100ps
// rpy_yuv_checker: watches the pixel pair, line length and packed triple channels of
// rgb565_to_packed_yuv420, predicts every triple and compares it field by field.
// Uses rpy_pkg and the channel interfaces of rpy_if.

module rpy_yuv_checker import rpy_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  rpy_pair_if   pix_i,
  rpy_cfg_if    cfg_i,
  rpy_triple_if yuv_i,
  output int    mismatch_count_o,
  output int    pending_o,
  output int    checked_o,
  output int    line_end_count_o
);

  typedef struct packed {
    logic [ByteW-1:0] chroma_byte;
    logic [ByteW-1:0] luma_left;
    logic [ByteW-1:0] luma_right;
    logic             chroma_is_v;
    logic             line_end;
  } triple_t;

  triple_t         expected_triples[$];
  logic [CfgW-1:0] line_pairs;
  int              column;
  logic            odd_line;
  int              mismatches;
  int              checked;
  int              line_ends;

  function automatic logic [ByteW-1:0] to_byte(int v);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return v[ByteW-1:0];
  endfunction

  // plain left shift to 8 bits, no replication of the top bits
  function automatic void split565(input logic [PixW-1:0] px,
                                   output int r, output int g, output int b);
    r = int'({px[15:11], 3'b000});
    g = int'({px[10:5], 2'b00});
    b = int'({px[4:0], 3'b000});
  endfunction

  function automatic logic [ByteW-1:0] luma(logic [PixW-1:0] px);
    int r, g, b;
    split565(px, r, g, b);
    return to_byte((77 * r + 150 * g + 29 * b) >>> 8);
  endfunction

  // converts one pair and advances the line position
  function automatic triple_t convert_pair(logic [PixW-1:0] left, logic [PixW-1:0] right,
                                           logic frame_start);
    triple_t t;
    int      r, g, b, span;
    span = (line_pairs == '0) ? 1 :
           (int'(line_pairs) > MaxLinePairs) ? MaxLinePairs : int'(line_pairs);
    if (frame_start) begin
      column   = 0;
      odd_line = 1'b0;
    end
    split565(left, r, g, b);
    // arithmetic shift floors negative sums
    if (odd_line) begin
      t.chroma_byte = to_byte(((128 * r - 107 * g - 21 * b) >>> 8) + 128);
    end else begin
      t.chroma_byte = to_byte(((-43 * r - 85 * g + 128 * b) >>> 8) + 128);
    end
    t.luma_left   = luma(left);
    t.luma_right  = luma(right);
    t.chroma_is_v = odd_line;
    t.line_end    = (column >= span - 1);
    if (t.line_end) begin
      column   = 0;
      odd_line = ~odd_line;
    end else begin
      column++;
    end
    return t;
  endfunction

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    triple_t want;
    if (!rst_ni) begin
      expected_triples.delete();
      line_pairs = PairsPerLineReset;
      column     = 0;
      odd_line   = 1'b0;
      mismatches = 0;
      checked    = 0;
      line_ends  = 0;
    end else begin
      if (yuv_i.valid && yuv_i.ready) begin
        if (expected_triples.size() == 0) begin
          $error("triple with no pair pending: chroma_byte %0d luma_left %0d luma_right %0d",
                 yuv_i.chroma_byte, yuv_i.luma_left, yuv_i.luma_right);
          mismatches++;
        end else begin
          want = expected_triples.pop_front();
          check_field("chroma_byte", want.chroma_byte, yuv_i.chroma_byte);
          check_field("luma_left", want.luma_left, yuv_i.luma_left);
          check_field("luma_right", want.luma_right, yuv_i.luma_right);
          check_field("chroma_is_v", want.chroma_is_v, yuv_i.chroma_is_v);
          check_field("line_end", want.line_end, yuv_i.line_end);
          checked++;
          if (want.line_end) line_ends++;
        end
      end
      if (cfg_i.valid && cfg_i.ready) line_pairs = cfg_i.data;
      if (pix_i.valid && pix_i.ready) begin
        expected_triples.push_back(convert_pair(pix_i.first_pixel, pix_i.second_pixel,
                                                pix_i.frame_start));
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_triples.size();
    checked_o        <= checked;
    line_end_count_o <= line_ends;
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// testbench: drives pixel pair requests, line length writes and output back pressure
// into rgb565_to_packed_yuv420 and gives the verdict. Uses rpy_pkg, rpy_if and
// rpy_yuv_checker.

module testbench;
  import rpy_pkg::*;

  localparam int HoldCycles = 48;

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   hold_asked;
  int   hold_done;
  int   pairs_sent;
  int   line_writes;
  int   mismatches;
  int   pending;
  int   checked;
  int   line_ends;

  rpy_pair_if   pix_if();
  rpy_cfg_if    cfg_if();
  rpy_triple_if yuv_if();

  rgb565_to_packed_yuv420 i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_if),
    .cfg_i  (cfg_if),
    .yuv_o  (yuv_if)
  );

  rpy_yuv_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .pix_i            (pix_if),
    .cfg_i            (cfg_if),
    .yuv_i            (yuv_if),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked),
    .line_end_count_o (line_ends)
  );

  always #2 clk = ~clk;

  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 16'hF800;
      3: return 16'h07E0;
      4: return 16'h001F;
      default: return PixW'($urandom);
    endcase
  endfunction

  task automatic send_pair(logic [PixW-1:0] left, logic [PixW-1:0] right, logic restart);
    while ($urandom_range(99) < idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid        <= 1'b1;
    pix_if.first_pixel  <= left;
    pix_if.second_pixel <= right;
    pix_if.frame_start  <= restart;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    pairs_sent++;
  endtask

  // stop offering and wait for every outstanding triple, plus the pipeline depth
  task automatic drain();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_line_pairs(logic [CfgW-1:0] pairs);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= pairs;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    line_writes++;
  endtask

  task automatic run_phase(int count, int idle, int stall, logic [CfgW-1:0] pairs,
                           int restart_pct, bit squeeze, bit pause_mid);
    write_line_pairs(pairs);
    idle_pct  = idle;
    stall_pct = stall;
    // long output hold while requests keep coming
    if (squeeze) hold_asked++;
    send_pair(pick_pixel(), pick_pixel(), 1'b1);
    for (int k = 1; k < count; k++) begin
      if (pause_mid && k == count / 2) drain();
      send_pair(pick_pixel(), pick_pixel(), $urandom_range(99) < restart_pct);
    end
  endtask

  // output side: random stalls, or a counted hold when one is asked for
  initial begin
    yuv_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        yuv_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done++;
      end else begin
        yuv_if.ready <= rst_n && ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    pix_if.valid        = 1'b0;
    pix_if.first_pixel  = '0;
    pix_if.second_pixel = '0;
    pix_if.frame_start  = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.data         = '0;
    rst_n               = 1'b0;
    idle_pct            = 0;
    stall_pct           = 0;
    hold_asked          = 0;
    hold_done           = 0;
    pairs_sent          = 0;
    line_writes         = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length of 320: range extremes and primaries on an even line
    send_pair(16'h0000, 16'hFFFF, 1'b1);
    send_pair(16'hFFFF, 16'h0000, 1'b0);
    send_pair(16'hF800, 16'h07E0, 1'b0);
    send_pair(16'h07E0, 16'h001F, 1'b0);
    send_pair(16'h001F, 16'hF800, 1'b0);
    // one pair per line, chroma alternates u and v
    write_line_pairs(11'd1);
    send_pair(16'hF800, 16'hFFFF, 1'b0);
    send_pair(16'h07E0, 16'h0000, 1'b0);
    send_pair(16'h001F, 16'hF800, 1'b0);
    send_pair(16'hFFFF, 16'h07E0, 1'b0);
    // zero length behaves as one
    write_line_pairs(11'd0);
    send_pair(16'hF800, 16'h001F, 1'b0);
    send_pair(16'h001F, 16'h07E0, 1'b0);
    // shorten the line while the column is already past its new end
    write_line_pairs(11'd8);
    send_pair(16'h1234, 16'hABCD, 1'b1);
    repeat (4) send_pair(pick_pixel(), pick_pixel(), 1'b0);
    write_line_pairs(11'd3);
    send_pair(16'h07E0, 16'hF800, 1'b0);
    send_pair(16'hF800, 16'h001F, 1'b0);
    // frame start in the middle of an odd line
    send_pair(16'h001F, 16'hFFFF, 1'b1);

    // oversized length saturates, no early wrap over a long run
    run_phase(450, 0, 0, 11'd2047, 0, 1'b1, 1'b0);
    run_phase(80, 58, 0, CfgW'($urandom_range(6, 1)), 4, 1'b0, 1'b0);
    run_phase(80, 0, 58, 11'd1, 4, 1'b0, 1'b0);
    run_phase(80, 29, 29, CfgW'($urandom_range(12, 2)), 5, 1'b0, 1'b1);
    run_phase(60, 29, 29, 11'd0, 3, 1'b0, 1'b0);
    run_phase(60, 0, 0, 11'd1024, 2, 1'b1, 1'b0);
    run_phase(60, 58, 0, 11'd1025, 2, 1'b0, 1'b0);
    run_phase(60, 0, 58, CfgW'($urandom_range(40, 2)), 6, 1'b0, 1'b0);

    pix_if.valid <= 1'b0;
    for (int w = 0; w < 20000 && pending != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending != 0) $error("%0d triples never arrived", pending);

    $display("testbench: %0d pairs sent, %0d triples compared, %0d line ends seen",
             pairs_sent, checked, line_ends);
    $display("testbench: %0d line length writes incl. 0, 1, 1024 and above, under stalls",
             line_writes);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

[sim.f]
design/rpy_pkg.sv
design/rpy_if.sv
design/rpy_line_ctrl.sv
design/rpy_convert.sv
design/rgb565_to_packed_yuv420.sv
sim/rpy_yuv_checker.sv
sim/testbench.sv
